>>> design/rdq_pkg.sv
// shared types, constants and codes for the record deque store
package rdq_pkg;

  localparam int DEPTH_DEF      = 32;
  localparam int DATA_WIDTH_DEF = 64;
  localparam int FIELD_W        = 64;
  localparam int LIST_LIMIT     = 32;

  typedef enum logic [2:0] {
    KIND_LIST       = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_PUSH_REAR  = 3'd2,
    KIND_POP_FRONT  = 3'd3,
    KIND_POP_REAR   = 3'd4,
    KIND_STEP       = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WAIT_POP,
    S_WAIT_LIST
  } state_e;

  typedef enum logic [1:0] {
    RD_FRONT,
    RD_REAR_M1,
    RD_LIST
  } rd_sel_e;

  typedef enum logic {
    WR_FRONT_M1,
    WR_REAR
  } wr_sel_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INC,
    OP_DEC
  } ptr_op_e;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_MEM,
    SRC_IN
  } out_src_e;

  typedef struct packed {
    logic [2:0]         kind;
    logic [FIELD_W-1:0] entry_data;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [FIELD_W-1:0] out_data;
    logic               last_item;
  } out_t;

  typedef struct packed {
    logic     mem_rd;
    rd_sel_e  rd_sel;
    logic     mem_wr;
    wr_sel_e  wr_sel;
    ptr_op_e  front_op;
    ptr_op_e  count_op;
    logic     list_start;
    logic     list_next;
    logic     out_load;
    out_src_e out_src;
    status_e  out_status;
    logic     out_last;
  } cmd_t;

  typedef struct packed {
    logic count_zero;
    logic count_full;
    logic list_more;
    logic out_free;
  } sts_t;

endpackage

>>> design/rdq_ctrl.sv
// operation sequencer for the record deque store
module rdq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic [2:0]     in_kind_i,
  input  rdq_pkg::sts_t  sts_i,
  output logic           in_ready_o,
  output rdq_pkg::cmd_t  cmd_o
);

  rdq_pkg::state_e state_q, state_d;
  logic            accept;

  assign in_ready_o = (state_q == rdq_pkg::S_IDLE) && sts_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rdq_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      rdq_pkg::S_IDLE: begin
        if (accept) begin
          case (rdq_pkg::kind_e'(in_kind_i))
            rdq_pkg::KIND_LIST: begin
              if (!sts_i.count_zero) state_d = rdq_pkg::S_WAIT_LIST;
            end
            rdq_pkg::KIND_POP_FRONT, rdq_pkg::KIND_POP_REAR: begin
              if (!sts_i.count_zero) state_d = rdq_pkg::S_WAIT_POP;
            end
            rdq_pkg::KIND_STEP: begin
              if (!sts_i.count_full && !sts_i.count_zero) state_d = rdq_pkg::S_WAIT_POP;
            end
            default: state_d = rdq_pkg::S_IDLE;
          endcase
        end
      end
      rdq_pkg::S_WAIT_POP: begin
        if (sts_i.out_free) state_d = rdq_pkg::S_IDLE;
      end
      rdq_pkg::S_WAIT_LIST: begin
        if (sts_i.out_free && !sts_i.list_more) state_d = rdq_pkg::S_IDLE;
      end
      default: state_d = rdq_pkg::S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o            = '0;
    cmd_o.rd_sel     = rdq_pkg::RD_FRONT;
    cmd_o.wr_sel     = rdq_pkg::WR_REAR;
    cmd_o.front_op   = rdq_pkg::OP_HOLD;
    cmd_o.count_op   = rdq_pkg::OP_HOLD;
    cmd_o.out_src    = rdq_pkg::SRC_ZERO;
    cmd_o.out_status = rdq_pkg::ST_OK;
    cmd_o.out_last   = 1'b1;
    case (state_q)
      rdq_pkg::S_IDLE: begin
        if (accept) begin
          case (rdq_pkg::kind_e'(in_kind_i))
            rdq_pkg::KIND_LIST: begin
              if (sts_i.count_zero) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = rdq_pkg::ST_EMPTY;
              end else begin
                cmd_o.mem_rd     = 1'b1;
                cmd_o.rd_sel     = rdq_pkg::RD_FRONT;
                cmd_o.list_start = 1'b1;
              end
            end
            rdq_pkg::KIND_PUSH_FRONT: begin
              cmd_o.out_load = 1'b1;
              if (sts_i.count_full) begin
                cmd_o.out_status = rdq_pkg::ST_FULL;
              end else begin
                cmd_o.mem_wr   = 1'b1;
                cmd_o.wr_sel   = rdq_pkg::WR_FRONT_M1;
                cmd_o.front_op = rdq_pkg::OP_DEC;
                cmd_o.count_op = rdq_pkg::OP_INC;
              end
            end
            rdq_pkg::KIND_PUSH_REAR: begin
              cmd_o.out_load = 1'b1;
              if (sts_i.count_full) begin
                cmd_o.out_status = rdq_pkg::ST_FULL;
              end else begin
                cmd_o.mem_wr   = 1'b1;
                cmd_o.wr_sel   = rdq_pkg::WR_REAR;
                cmd_o.count_op = rdq_pkg::OP_INC;
              end
            end
            rdq_pkg::KIND_POP_FRONT: begin
              if (sts_i.count_zero) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = rdq_pkg::ST_EMPTY;
              end else begin
                cmd_o.mem_rd   = 1'b1;
                cmd_o.rd_sel   = rdq_pkg::RD_FRONT;
                cmd_o.front_op = rdq_pkg::OP_INC;
                cmd_o.count_op = rdq_pkg::OP_DEC;
              end
            end
            rdq_pkg::KIND_POP_REAR: begin
              if (sts_i.count_zero) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = rdq_pkg::ST_EMPTY;
              end else begin
                cmd_o.mem_rd   = 1'b1;
                cmd_o.rd_sel   = rdq_pkg::RD_REAR_M1;
                cmd_o.count_op = rdq_pkg::OP_DEC;
              end
            end
            rdq_pkg::KIND_STEP: begin
              if (sts_i.count_full) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_status = rdq_pkg::ST_FULL;
              end else if (sts_i.count_zero) begin
                // pushed word comes straight back
                cmd_o.out_load = 1'b1;
                cmd_o.out_src  = rdq_pkg::SRC_IN;
              end else begin
                cmd_o.mem_wr   = 1'b1;
                cmd_o.wr_sel   = rdq_pkg::WR_REAR;
                cmd_o.mem_rd   = 1'b1;
                cmd_o.rd_sel   = rdq_pkg::RD_FRONT;
                cmd_o.front_op = rdq_pkg::OP_INC;
              end
            end
            default: cmd_o.out_load = 1'b0;
          endcase
        end
      end
      rdq_pkg::S_WAIT_POP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_src  = rdq_pkg::SRC_MEM;
        end
      end
      rdq_pkg::S_WAIT_LIST: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_src  = rdq_pkg::SRC_MEM;
          cmd_o.out_last = !sts_i.list_more;
          if (sts_i.list_more) begin
            cmd_o.mem_rd    = 1'b1;
            cmd_o.rd_sel    = rdq_pkg::RD_LIST;
            cmd_o.list_next = 1'b1;
          end
        end
      end
      default: cmd_o.out_load = 1'b0;
    endcase
  end

endmodule

>>> design/rdq_datapath.sv
// ring storage, pointers, list counter and output register of the deque
module rdq_datapath #(
  parameter int DEPTH      = rdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [rdq_pkg::FIELD_W-1:0] entry_data_i,
  input  rdq_pkg::cmd_t               cmd_i,
  output rdq_pkg::sts_t               sts_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output rdq_pkg::out_t               out_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = PW + 1;

  function automatic logic [PW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= SW'(DEPTH)) ? s - SW'(DEPTH) : s;
    return r[PW-1:0];
  endfunction

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;
  logic [PW-1:0]         front_q, front_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         idx_q, n_q;
  logic                  out_valid_q;
  rdq_pkg::out_t         out_q;

  logic [SW-1:0]         front_ext;
  logic [PW-1:0]         front_m1, front_p1, rear, rear_m1, list_addr;
  logic [PW-1:0]         rd_addr, wr_addr;
  logic [DATA_WIDTH-1:0] in_word;
  logic                  out_free;

  assign front_ext = SW'(front_q);
  assign front_m1  = (front_q == '0) ? PW'(DEPTH - 1) : front_q - PW'(1);
  assign front_p1  = wrap(front_ext + SW'(1));
  assign rear      = wrap(front_ext + SW'(count_q));
  assign rear_m1   = wrap(front_ext + SW'(count_q) - SW'(1));
  assign list_addr = wrap(front_ext + SW'(idx_q) + SW'(1));
  assign in_word   = entry_data_i[DATA_WIDTH-1:0];
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    case (cmd_i.rd_sel)
      rdq_pkg::RD_FRONT:   rd_addr = front_q;
      rdq_pkg::RD_REAR_M1: rd_addr = rear_m1;
      rdq_pkg::RD_LIST:    rd_addr = list_addr;
      default:             rd_addr = front_q;
    endcase
  end

  assign wr_addr = (cmd_i.wr_sel == rdq_pkg::WR_FRONT_M1) ? front_m1 : rear;

  always_comb begin
    case (cmd_i.front_op)
      rdq_pkg::OP_INC: front_d = front_p1;
      rdq_pkg::OP_DEC: front_d = front_m1;
      default:         front_d = front_q;
    endcase
  end

  always_comb begin
    case (cmd_i.count_op)
      rdq_pkg::OP_INC: count_d = count_q + CW'(1);
      rdq_pkg::OP_DEC: count_d = count_q - CW'(1);
      default:         count_d = count_q;
    endcase
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem_q[wr_addr] <= in_word;
    end
    if (cmd_i.mem_rd) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // list walk and result beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.list_start) begin
      idx_q <= '0;
      if (32'(count_q) > 32'(rdq_pkg::LIST_LIMIT)) begin
        n_q <= CW'(rdq_pkg::LIST_LIMIT);
      end else begin
        n_q <= count_q;
      end
    end else if (cmd_i.list_next) begin
      idx_q <= idx_q + CW'(1);
    end
    if (cmd_i.out_load) begin
      out_q.status    <= cmd_i.out_status;
      out_q.last_item <= cmd_i.out_last;
      case (cmd_i.out_src)
        rdq_pkg::SRC_MEM: out_q.out_data <= rdq_pkg::FIELD_W'(rdata_q);
        rdq_pkg::SRC_IN:  out_q.out_data <= rdq_pkg::FIELD_W'(in_word);
        default:          out_q.out_data <= '0;
      endcase
    end
  end

  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.count_full = (count_q == CW'(DEPTH));
  assign sts_o.list_more  = ({1'b0, idx_q} + (CW + 1)'(1)) < {1'b0, n_q};
  assign sts_o.out_free   = out_free;

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> design/record_deque_store.sv
// Bounded double-ended queue of record words kept as a ring in a single-port-write,
// registered-read memory of DEPTH words; there is no clearing pass after reset.
// Pushes, and any item that ends in an empty or full status, give their beat in the cycle
// after acceptance, as does a queue step on an empty queue, which hands its word straight
// back; pops and the queue step on a non-empty queue give theirs through the registered
// memory read and then the output register. A list streams one beat per cycle while the
// output register is free, after the registered read, for at most 32 entries, front first.
// The next item is accepted once the sequencer is idle and the output register is free.
module record_deque_store #(
  parameter int DEPTH      = rdq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  rdq_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rdq_pkg::out_t out_o
);

  rdq_pkg::cmd_t cmd;
  rdq_pkg::sts_t sts;

  rdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_kind_i  (in_i.kind),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd)
  );

  rdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_data_i (in_i.entry_data),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .out_o        (out_o)
  );

`ifndef ASSERT_OFF
  a_ready_needs_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (!out_valid_o || out_ready_i))
    else $error("input taken while the output register is held");

  a_push_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && sts.count_full &&
     (in_i.kind == rdq_pkg::KIND_PUSH_REAR || in_i.kind == rdq_pkg::KIND_PUSH_FRONT))
    |=> (out_valid_o && out_o.status == rdq_pkg::ST_FULL && out_o.last_item))
    else $error("push on a full queue did not report full");

  a_pop_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !sts.count_zero && in_i.kind == rdq_pkg::KIND_POP_FRONT)
    |-> ##2 (out_valid_o && out_o.status == rdq_pkg::ST_OK && out_o.last_item))
    else $error("pop on a non-empty queue gave no ok beat");
`endif

endmodule
